>>> src/piecewise_linear_sensor_calibration_defines.svh
// ----------------------------------------------------------------------------
// piecewise linear sensor calibration assertion macros
// shared concurrent assertion helpers, clocked on clk_i, idle in reset
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_SENSOR_CALIBRATION_DEFINES_SVH
`define PIECEWISE_LINEAR_SENSOR_CALIBRATION_DEFINES_SVH

// same-cycle implication
`define PLSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("plsc assertion failed");

// next-cycle implication
`define PLSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plsc assertion failed");

`endif

>>> src/plsc_pkg.sv
// ----------------------------------------------------------------------------
// plsc_pkg
// widths, register indexes and the word carried along the divider cells
// ----------------------------------------------------------------------------
package plsc_pkg;

  localparam int unsigned RAW_W     = 24;
  localparam int unsigned PRES_W    = 17;
  localparam int unsigned PROD_W    = RAW_W + PRES_W;
  localparam int unsigned NUM_W     = PROD_W + 1;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SLOTS     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RAW_ANCHOR_0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_ANCHOR_1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_ANCHOR_2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_ANCHOR_3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_ANCHOR_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_ANCHOR_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_ANCHOR_3 = 3'd6;

  typedef logic [SLOTS-1:0][RAW_W-1:0]  raw_bank_t;
  typedef logic [SLOTS-1:0][PRES_W-1:0] pres_bank_t;

  typedef struct packed {
    logic              inv;
    logic              zero;
    logic              ovf;
    logic [RAW_W-1:0]  rem;
    logic [RAW_W-1:0]  nq;
    logic [RAW_W-1:0]  divisor;
    logic [PRES_W-1:0] p0;
  } div_word_t;

endpackage

>>> src/plsc_front.sv
// ----------------------------------------------------------------------------
// plsc_front
// profile check, segment pick, span multiply, rounding add and range check, four stages
// ----------------------------------------------------------------------------
module plsc_front #(
  parameter int unsigned ANCHOR_COUNT      = 4,
  parameter int unsigned PRESSURE_MAX      = 129290,
  parameter int unsigned MIN_RAW_SPAN      = 1000,
  parameter int unsigned MIN_PRESSURE_SPAN = 100
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [plsc_pkg::RAW_W-1:0]    sample_i,
  input  plsc_pkg::raw_bank_t           raw_i,
  input  plsc_pkg::pres_bank_t          pres_i,
  output logic                          valid_o,
  output plsc_pkg::div_word_t           word_o
);

  localparam int unsigned RW = plsc_pkg::RAW_W;
  localparam int unsigned PW = plsc_pkg::PRES_W;
  localparam logic [RW-1:0] PMAX     = RW'(PRESSURE_MAX);
  localparam logic [RW-1:0] RAW_MIN  = RW'(MIN_RAW_SPAN);
  localparam logic [PW-1:0] PRES_MIN = PW'(MIN_PRESSURE_SPAN);

  // stage a
  logic          prof_ok;
  logic [RW-1:0] sel_r0, sel_r1;
  logic [PW-1:0] sel_p0, sel_p1;
  logic          a_valid_q;
  logic          a_inv_q, a_zero_q;
  logic [RW-1:0] a_dx_q, a_span_q;
  logic [PW-1:0] a_dp_q, a_p0_q;

  always_comb begin
    prof_ok = 1'b1;
    for (int i = 0; i < ANCHOR_COUNT; i++) begin
      if ({{(RW-PW){1'b0}}, pres_i[i]} > PMAX) prof_ok = 1'b0;
    end
    for (int i = 1; i < ANCHOR_COUNT; i++) begin
      if (raw_i[i] <= raw_i[i-1]) prof_ok = 1'b0;
      else if (raw_i[i] - raw_i[i-1] < RAW_MIN) prof_ok = 1'b0;
      if (pres_i[i] <= pres_i[i-1]) prof_ok = 1'b0;
      else if (pres_i[i] - pres_i[i-1] < PRES_MIN) prof_ok = 1'b0;
    end
  end

  // lowest segment whose upper anchor covers the sample, else the last one
  always_comb begin
    sel_r0 = raw_i[ANCHOR_COUNT-2];
    sel_r1 = raw_i[ANCHOR_COUNT-1];
    sel_p0 = pres_i[ANCHOR_COUNT-2];
    sel_p1 = pres_i[ANCHOR_COUNT-1];
    for (int k = ANCHOR_COUNT - 2; k >= 0; k--) begin
      if (sample_i <= raw_i[k+1]) begin
        sel_r0 = raw_i[k];
        sel_r1 = raw_i[k+1];
        sel_p0 = pres_i[k];
        sel_p1 = pres_i[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_inv_q  <= !prof_ok;
    a_zero_q <= (sample_i <= raw_i[0]);
    a_dx_q   <= sample_i - sel_r0;
    a_span_q <= sel_r1 - sel_r0;
    a_dp_q   <= sel_p1 - sel_p0;
    a_p0_q   <= sel_p0;
  end

  // stage b: multiply
  logic                         b_valid_q;
  logic                         b_inv_q, b_zero_q;
  logic [plsc_pkg::PROD_W-1:0]  b_prod_q;
  logic [RW-1:0]                b_span_q;
  logic [PW-1:0]                b_p0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_inv_q  <= a_inv_q;
    b_zero_q <= a_zero_q;
    b_prod_q <= {{PW{1'b0}}, a_dx_q} * {{RW{1'b0}}, a_dp_q};
    b_span_q <= a_span_q;
    b_p0_q   <= a_p0_q;
  end

  // stage c: rounding add
  logic                        c_valid_q;
  logic                        c_inv_q, c_zero_q;
  logic [plsc_pkg::NUM_W-1:0]  c_num_q;
  logic [RW-1:0]               c_span_q;
  logic [PW-1:0]               c_p0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_inv_q  <= b_inv_q;
    c_zero_q <= b_zero_q;
    c_num_q  <= {1'b0, b_prod_q} + {{(plsc_pkg::NUM_W-RW+1){1'b0}}, b_span_q[RW-1:1]};
    c_span_q <= b_span_q;
    c_p0_q   <= b_p0_q;
  end

  // stage d: quotient too wide for the cells means saturation
  logic [plsc_pkg::NUM_W-RW-1:0] num_hi;
  plsc_pkg::div_word_t           word_d, word_q;
  logic                          d_valid_q;

  assign num_hi = c_num_q[plsc_pkg::NUM_W-1:RW];

  always_comb begin
    word_d.inv     = c_inv_q;
    word_d.zero    = c_zero_q;
    word_d.ovf     = ({{(2*RW-plsc_pkg::NUM_W){1'b0}}, num_hi} >= c_span_q);
    word_d.rem     = {{(2*RW-plsc_pkg::NUM_W){1'b0}}, num_hi};
    word_d.nq      = c_num_q[RW-1:0];
    word_d.divisor = c_span_q;
    word_d.p0      = c_p0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = d_valid_q;
  assign word_o  = word_q;

endmodule

>>> src/plsc_div_cell.sv
// ----------------------------------------------------------------------------
// plsc_div_cell
// one restoring division step, one quotient bit, registered toward the next cell
// ----------------------------------------------------------------------------
module plsc_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  plsc_pkg::div_word_t word_i,
  output logic                valid_o,
  output plsc_pkg::div_word_t word_o
);

  localparam int unsigned RW = plsc_pkg::RAW_W;

  logic [RW:0]         trial;
  logic                fit;
  plsc_pkg::div_word_t word_d, word_q;
  logic                valid_q;

  always_comb begin
    trial       = {word_i.rem, word_i.nq[RW-1]};
    fit         = (trial >= {1'b0, word_i.divisor});
    word_d      = word_i;
    word_d.rem  = fit ? RW'(trial - {1'b0, word_i.divisor}) : trial[RW-1:0];
    word_d.nq   = {word_i.nq[RW-2:0], fit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> src/piecewise_linear_sensor_calibration.sv
// ----------------------------------------------------------------------------
// piecewise linear sensor calibration
// raw sensor word to pressure in 0.01 mmHg through a calibrated anchor profile
// ----------------------------------------------------------------------------
// A raw sample is taken on every cycle that start is high; busy never rises.
// Each word comes back on done_o in order, through four front stages
// (profile check and segment pick, multiply, rounding add, range check),
// 24 divider cells giving one quotient bit each, and the saturating output
// register. The receiver cannot stall, so the caller must take done_o words
// as they appear. The caller must write anchors through the cfg port only
// while no sample is in flight; the block itself does not enforce this.
module piecewise_linear_sensor_calibration #(
  parameter int unsigned ANCHOR_COUNT      = 4,
  parameter int unsigned PRESSURE_MAX      = 129290,
  parameter int unsigned MIN_RAW_SPAN      = 1000,
  parameter int unsigned MIN_PRESSURE_SPAN = 100
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [plsc_pkg::RAW_W-1:0]        raw_sample_i,
  output logic                              done_o,
  output logic [plsc_pkg::PRES_W-1:0]       pressure_value_o,
  output logic                              profile_invalid_o,
  input  logic                              cfg_we_i,
  input  logic [plsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [plsc_pkg::RAW_W-1:0]        cfg_wdata_i
);

  `include "piecewise_linear_sensor_calibration_defines.svh"

  localparam int unsigned RW      = plsc_pkg::RAW_W;
  localparam int unsigned PW      = plsc_pkg::PRES_W;
  localparam int unsigned CELLS   = RW;
  localparam int unsigned LATENCY = 4 + CELLS + 1;
  localparam logic [RW-1:0] PMAX  = RW'(PRESSURE_MAX);

  // calibration registers
  plsc_pkg::raw_bank_t raw_q;
  logic [3:1][PW-1:0]  pres_q;
  plsc_pkg::pres_bank_t pres_bank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q  <= '0;
      pres_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plsc_pkg::REG_RAW_ANCHOR_0:      raw_q[0]  <= cfg_wdata_i;
        plsc_pkg::REG_RAW_ANCHOR_1:      raw_q[1]  <= cfg_wdata_i;
        plsc_pkg::REG_RAW_ANCHOR_2:      raw_q[2]  <= cfg_wdata_i;
        plsc_pkg::REG_RAW_ANCHOR_3:      raw_q[3]  <= cfg_wdata_i;
        plsc_pkg::REG_PRESSURE_ANCHOR_1: pres_q[1] <= cfg_wdata_i[PW-1:0];
        plsc_pkg::REG_PRESSURE_ANCHOR_2: pres_q[2] <= cfg_wdata_i[PW-1:0];
        plsc_pkg::REG_PRESSURE_ANCHOR_3: pres_q[3] <= cfg_wdata_i[PW-1:0];
        default: ;
      endcase
    end
  end

  assign pres_bank = {pres_q[3], pres_q[2], pres_q[1], {PW{1'b0}}};
  assign busy      = 1'b0;

  // front stages
  logic                chain_valid [CELLS+1];
  plsc_pkg::div_word_t chain_word  [CELLS+1];

  plsc_front #(
    .ANCHOR_COUNT     (ANCHOR_COUNT),
    .PRESSURE_MAX     (PRESSURE_MAX),
    .MIN_RAW_SPAN     (MIN_RAW_SPAN),
    .MIN_PRESSURE_SPAN(MIN_PRESSURE_SPAN)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .sample_i(raw_sample_i),
    .raw_i   (raw_q),
    .pres_i  (pres_bank),
    .valid_o (chain_valid[0]),
    .word_o  (chain_word[0])
  );

  // divider cell row
  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    plsc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(chain_valid[c]),
      .word_i (chain_word[c]),
      .valid_o(chain_valid[c+1]),
      .word_o (chain_word[c+1])
    );
  end

  // offset, saturation and output word
  plsc_pkg::div_word_t last_word;
  logic [RW:0]         sum;
  logic                sat;
  logic [PW-1:0]       value_d;
  logic                done_q, inv_q;
  logic [PW-1:0]       value_q;

  assign last_word = chain_word[CELLS];

  always_comb begin
    sum = {1'b0, last_word.nq} + {{(RW-PW+1){1'b0}}, last_word.p0};
    sat = last_word.ovf || (sum > {1'b0, PMAX});
    if (last_word.inv || last_word.zero) begin
      value_d = '0;
    end else if (sat) begin
      value_d = PMAX[PW-1:0];
    end else begin
      value_d = sum[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_valid[CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    inv_q   <= last_word.inv;
  end

  assign done_o            = done_q;
  assign pressure_value_o  = value_q;
  assign profile_invalid_o = inv_q;

  `PLSC_ASSERT_IMPL(a_latency, start && !busy, ##LATENCY done_o)
  `PLSC_ASSERT_IMPL(a_invalid_zero, done_o && profile_invalid_o, pressure_value_o == '0)
  `PLSC_ASSERT_NEXT(a_invalid_flag, chain_valid[CELLS] && last_word.inv, done_o && profile_invalid_o)

endmodule
